### rtl/sha_pkg.sv
// ============================================================================
// sha_pkg
// Shared types and constants for the SHA-256 stream hasher.
// ============================================================================
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    // Control from the sequencer into the compression engine
    typedef struct packed {
        logic       start;
        logic       init_chain;
    } eng_ctl_t;

    typedef struct packed {
        logic       busy;
    } eng_sts_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_OFFSET = 7'd56;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        begin
            r = 32'h0;
            unique case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                3'd7: r = 32'h5be0cd19;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
        32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
        32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
        32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
        32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
        32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
        32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
        32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
        32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
        32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
        32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

endpackage

### rtl/sha_in_if.sv
// ============================================================================
// sha_in_if
// Valid/ready channel carrying one input word.
// ============================================================================
interface sha_in_if;
    import sha_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/sha_out_if.sv
// ============================================================================
// sha_out_if
// Valid/ready channel carrying one digest word.
// ============================================================================
interface sha_out_if;
    import sha_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/sha_engine.sv
// ============================================================================
// sha_engine
// Compression engine: block bytes in a 64x8 memory, message schedule in a
// 16-word rolling window, chaining words in an 8x32 memory.
// ============================================================================
module sha_engine (
    input  logic              clk,
    input  logic              rst_n,
    // byte write port into the block buffer
    input  logic              buf_we,
    input  logic [5:0]        buf_addr,
    input  logic [7:0]        buf_wdata,
    input  sha_pkg::eng_ctl_t ctl,
    output sha_pkg::eng_sts_t sts,
    // digest read port
    input  logic [2:0]        dig_addr,
    output logic [31:0]       dig_rdata
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        EN_IDLE, EN_LOAD, EN_ROUND, EN_RDCH, EN_ADD, EN_INIT
    } en_state_t;

    logic [7:0]  buf_mem [64];
    logic [31:0] chain_mem [8];
    logic [7:0]  buf_rd_reg;
    logic [31:0] chain_rd_reg;

    en_state_t   st_reg, st_next;
    logic [6:0]  cnt_reg, cnt_next;   // load: byte addr issued; round: t
    logic [31:0] w_reg [16];          // schedule window, w_reg[15] newest
    logic [31:0] v_reg [8];
    logic [31:0] acc_reg;             // byte assembly for load
    logic [3:0]  ld_cnt_reg;          // words assembled

    logic [5:0]  buf_raddr;
    logic [2:0]  ch_raddr;
    logic        ch_we;
    logic [2:0]  ch_waddr;
    logic [31:0] ch_wdata;

    // Block buffer memory
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_addr] <= buf_wdata;
        end
        buf_rd_reg <= buf_mem[buf_raddr];
    end

    // Chaining word memory
    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            chain_mem[ch_waddr] <= ch_wdata;
        end
        chain_rd_reg <= chain_mem[ch_raddr];
    end

    assign buf_raddr = cnt_reg[5:0];
    assign dig_rdata = chain_rd_reg;

    always_comb
    begin
        ch_raddr = dig_addr;
        if (st_reg == EN_LOAD || st_reg == EN_RDCH || st_reg == EN_ADD)
        begin
            ch_raddr = cnt_reg[2:0];
        end
    end

    // Round function
    logic [31:0] s0, s1, wt, big0, big1, ch_f, maj_f, sum1, sum2, w_new;
    always_comb
    begin
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        wt = w_reg[0];
        big1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
             ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch_f = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
             ^ {v_reg[0][21:0], v_reg[0][31:22]};
        maj_f = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        sum1 = v_reg[7] + big1 + ch_f + ROUND_K[cnt_reg[5:0]] + wt;
        sum2 = big0 + maj_f;
    end

    // Next state
    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        unique case (st_reg)
            EN_IDLE:
            begin
                cnt_next = '0;
                if (ctl.init_chain)
                begin
                    st_next = EN_INIT;
                end
                else if (ctl.start)
                begin
                    st_next = EN_LOAD;
                end
            end
            EN_LOAD:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (ld_cnt_reg == 4'd15 && cnt_reg == 7'd64)
                begin
                    st_next = EN_ROUND;
                    cnt_next = '0;
                end
            end
            EN_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    st_next = EN_RDCH;
                    cnt_next = '0;
                end
            end
            EN_RDCH:
            begin
                st_next = EN_ADD;
            end
            EN_ADD:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd7)
                begin
                    st_next = EN_IDLE;
                end
                else
                begin
                    st_next = EN_RDCH;
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            EN_INIT:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd7)
                begin
                    st_next = EN_IDLE;
                end
            end
            default: st_next = EN_IDLE;
        endcase
    end

    // Chain memory write: init or add-back
    always_comb
    begin
        ch_we = 1'b0;
        ch_waddr = cnt_reg[2:0];
        ch_wdata = init_hash(cnt_reg[2:0]);
        if (st_reg == EN_INIT)
        begin
            ch_we = 1'b1;
        end
        else if (st_reg == EN_ADD)
        begin
            ch_we = 1'b1;
            ch_wdata = chain_rd_reg + v_reg[0];
        end
    end

    assign sts.busy = (st_reg != EN_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= EN_INIT;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (st_reg == EN_IDLE)
        begin
            ld_cnt_reg <= '0;
        end
        if (st_reg == EN_LOAD)
        begin
            // chaining words read in load cycles 0..7 are registered and land here in the next cycle
            if (cnt_reg >= 7'd1 && cnt_reg <= 7'd8)
            begin
                v_reg[cnt_reg[2:0] - 3'd1] <= chain_rd_reg;
            end
            if (cnt_reg != 7'd0)
            begin
                acc_reg <= {acc_reg[23:0], buf_rd_reg};
                if (cnt_reg[1:0] == 2'd0)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= {acc_reg[23:0], buf_rd_reg};
                    if (cnt_reg != 7'd64)
                    begin
                        ld_cnt_reg <= ld_cnt_reg + 4'd1;
                    end
                end
            end
        end
        if (st_reg == EN_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + sum1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= sum1 + sum2;
        end
        if (st_reg == EN_ADD)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i + 1];
            end
            v_reg[7] <= v_reg[0];
        end
    end

`ifndef SYNTH
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == EN_ROUND) |-> !buf_we)
        else $error("buffer written during compression");
    a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == EN_ROUND && cnt_reg == 7'd63) |=> (st_reg == EN_RDCH))
        else $error("round sequence broken");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && st_reg != EN_IDLE) |-> 1'b0)
        else $error("start while busy");
`endif
endmodule

### rtl/sha256_stream_hasher_core.sv
// ============================================================================
// sha256_stream_hasher_core
// SHA-256 over a byte stream; a finish word pads and emits 8 digest words.
// ============================================================================
// Channel   Dir  Payload                              Accept
// in_ch     in   kind, data_byte                      valid & ready
// out_ch    out  digest_word, word_index, last_word   valid & ready
//
// A byte is taken only while the core is idle and the engine is not busy;
// every 64th byte starts a block (byte loads, 64 rounds, a chain read and an
// add-back per word) set by the single round unit and the byte-wide buffer
// memory port. Finish pads byte by byte (one or two blocks) then emits eight
// words with output stalls; after reset the chain memory is loaded before input.
module sha256_stream_hasher_core (
    input logic clk,
    input logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

    ctl_state_t  st_reg, st_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] bytes_reg, bytes_next;
    logic [3:0]  pad_reg, pad_next;      // length bytes written so far
    logic        pad_hi_reg, pad_hi_next; // 0x80 already written
    logic [3:0]  emit_reg, emit_next;    // bit 3: read issued, [2:0] index
    logic        ovalid_reg, ovalid_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        rd_wait_reg, rd_wait_next;

    logic        buf_we;
    logic [7:0]  buf_wdata;
    eng_ctl_t    ectl;
    eng_sts_t    ests;
    logic [31:0] dig_rdata;
    logic [63:0] bit_count;

    sha_engine u_eng (
        .clk(clk), .rst_n(rst_n),
        .buf_we(buf_we), .buf_addr(fill_reg), .buf_wdata(buf_wdata),
        .ctl(ectl), .sts(ests),
        .dig_addr(emit_reg[2:0]), .dig_rdata(dig_rdata)
    );

    assign bit_count = {bytes_reg, 3'b000};
    assign in_ch.ready = (st_reg == ST_IDLE) && !ests.busy;

    logic [31:0] odata_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload.digest_word = odata_reg;
    assign out_ch.payload.word_index = oidx_reg;
    assign out_ch.payload.last_word = (oidx_reg == 3'd7);

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready && in_ch.payload.kind)
                begin
                    st_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (!ests.busy && pad_reg == 4'd8)
                begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (ovalid_reg && out_ch.ready && oidx_reg == 3'd7)
                begin
                    st_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!ests.busy)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        fill_next = fill_reg;
        bytes_next = bytes_reg;
        pad_next = pad_reg;
        pad_hi_next = pad_hi_reg;
        emit_next = emit_reg;
        ovalid_next = ovalid_reg;
        oidx_next = oidx_reg;
        rd_wait_next = 1'b0;
        buf_we = 1'b0;
        buf_wdata = in_ch.payload.data_byte;
        ectl.start = 1'b0;
        ectl.init_chain = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                pad_next = '0;
                pad_hi_next = 1'b0;
                emit_next = '0;
                if (in_ch.valid && in_ch.ready && !in_ch.payload.kind)
                begin
                    buf_we = 1'b1;
                    bytes_next = bytes_reg + 61'd1;
                    fill_next = fill_reg + 6'd1;
                    ectl.start = (fill_reg == 6'd63);
                end
            end
            ST_PAD:
            begin
                if (!ests.busy && pad_reg != 4'd8)
                begin
                    buf_we = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    ectl.start = (fill_reg == 6'd63);
                    if (!pad_hi_reg)
                    begin
                        buf_wdata = PAD_BYTE;
                        pad_hi_next = 1'b1;
                    end
                    // length starts exactly at offset 56, possibly in the next block
                    else if (pad_reg != 4'd0 || {1'b0, fill_reg} == LEN_OFFSET)
                    begin
                        buf_wdata = bit_count[63 - 8 * (fill_reg[2:0]) -: 8];
                        pad_next = pad_reg + 4'd1;
                    end
                    else
                    begin
                        buf_wdata = 8'h00;
                    end
                end
            end
            ST_EMIT:
            begin
                // issue read, data registered next cycle
                if (!ovalid_reg && !rd_wait_reg && !emit_reg[3])
                begin
                    rd_wait_next = 1'b1;
                    emit_next = {1'b1, emit_reg[2:0]};
                end
                if (rd_wait_reg)
                begin
                    ovalid_next = 1'b1;
                    oidx_next = emit_reg[2:0];
                end
                if (ovalid_reg && out_ch.ready)
                begin
                    ovalid_next = 1'b0;
                    emit_next = {1'b0, emit_reg[2:0] + 3'd1};
                    if (oidx_reg == 3'd7)
                    begin
                        ectl.init_chain = 1'b1;
                        bytes_next = '0;
                        fill_next = '0;
                    end
                end
            end
            ST_ADD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            fill_reg <= '0;
            bytes_reg <= '0;
            pad_reg <= '0;
            pad_hi_reg <= 1'b0;
            emit_reg <= '0;
            ovalid_reg <= 1'b0;
            oidx_reg <= '0;
            rd_wait_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            fill_reg <= fill_next;
            bytes_reg <= bytes_next;
            pad_reg <= pad_next;
            pad_hi_reg <= pad_hi_next;
            emit_reg <= emit_next;
            ovalid_reg <= ovalid_next;
            oidx_reg <= oidx_next;
            rd_wait_reg <= rd_wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_wait_reg)
        begin
            odata_reg <= dig_rdata;
        end
    end

`ifndef SYNTH
    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (st_reg == ST_EMIT))
        else $error("digest word outside emit");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ests.busy |-> !in_ch.ready)
        else $error("input taken while engine busy");
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && oidx_reg != 3'd7)
        |=> (emit_reg[2:0] == $past(oidx_reg) + 3'd1))
        else $error("digest index skipped");
`endif
endmodule

### test/sha256_stream_hasher_core_checker.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core_checker
// Watches both channels, hashes the accepted input words with its own SHA-256
// model and compares every digest word against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_checker
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink  in_mon,
    sha_out_if.sink out_mon,
    output int      fail_count,
    output int      pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
        32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
        32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
        32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
        32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
        32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
        32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
        32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
        32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
        32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
        32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [60:0] msg_bytes;
    out_word_t   digest_q [$];

    assign pending_words = digest_q.size();

    function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

    // One 64-round compression of the current block into the chain
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        v = chain;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            chain[t] = chain[t] + v[t];
    endtask

    task automatic put_byte(input logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 64)
        begin
            compress_block();
            fill = 0;
        end
    endtask

    // Absorb a byte, or pad and queue the eight digest words
    task automatic hash_word(input in_word_t w);
        logic [63:0] bits;
        out_word_t   o;
        if (!w.kind)
        begin
            msg_bytes = msg_bytes + 61'd1;
            put_byte(w.data_byte);
        end
        else
        begin
            bits = {msg_bytes, 3'b000};
            put_byte(PAD_BYTE);
            while (fill != int'(LEN_OFFSET))
                put_byte(8'h00);
            for (int i = 0; i < 8; i++)
                put_byte(bits[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                o.digest_word = chain[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_q.push_back(o);
            end
            chain     = IV;
            fill      = 0;
            msg_bytes = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        chain      = IV;
        fill       = 0;
        msg_bytes  = '0;
    end

    // Sample both channels at each edge
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if (in_mon.valid && in_mon.ready)
                hash_word(in_mon.payload);
            if (out_mon.valid && out_mon.ready)
            begin
                if (digest_q.size() == 0)
                    report_mismatch("unexpected word", out_mon.payload.digest_word,
                                    32'd0);
                else
                begin
                    exp_w = digest_q.pop_front();
                    if (out_mon.payload.digest_word !== exp_w.digest_word)
                        report_mismatch("digest_word", out_mon.payload.digest_word,
                                        exp_w.digest_word);
                    if (out_mon.payload.word_index !== exp_w.word_index)
                        report_mismatch("word_index", 32'(out_mon.payload.word_index),
                                        32'(exp_w.word_index));
                    if (out_mon.payload.last_word !== exp_w.last_word)
                        report_mismatch("last_word", 32'(out_mon.payload.last_word),
                                        32'(exp_w.last_word));
                end
            end
        end
    end

endmodule

### test/sha256_stream_hasher_core_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core_tb
// Feeds messages of many lengths into the hasher under several idle and
// stall mixes, including a long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    int   src_idle_pct;
    int   snk_stall_pct;
    bit   hold_off;
    int   quiet_cycles = 0;

    sha_in_if  in_ch();
    sha_out_if out_ch();

    sha256_stream_hasher_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    sha256_stream_hasher_core_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch.sink),
        .out_mon       (out_ch.sink),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sha256_stream_hasher_core test failed");
            $finish;
        end
    end

    // Offer one word and hold it until accepted
    task automatic send_word(input logic k, input logic [7:0] b);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.payload.kind  <= k;
        in_ch.payload.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_message(input int len, input int pattern);
        for (int i = 0; i < len; i++)
            case (pattern)
                0: send_word(1'b0, 8'h00);
                1: send_word(1'b0, 8'hff);
                default: send_word(1'b0, 8'($urandom_range(255)));
            endcase
        send_word(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 15) return $urandom_range(52, 60);
        if (r < 25) return $urandom_range(62, 66);
        if (r < 30) return $urandom_range(110, 130);
        return $urandom_range(0, 40);
    endfunction

    initial
    begin
        int sent;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        hold_off      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty, padding boundaries, all-zero and all-one bytes
        send_message(0, 2);
        send_message(3, 2);
        send_message(55, 0);
        send_message(56, 1);
        send_message(64, 2);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hff);
        drain();

        // Long output hold-off with a second message held back at the stalled input
        hold_off <= 1'b1;
        fork
            begin
                send_message(130, 2);
                send_message(8, 2);
            end
            begin
                repeat (3000) @(posedge clk);
                hold_off <= 1'b0;
            end
        join
        drain();

        // Random phases over the idle and stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
                default: begin src_idle_pct = 23; snk_stall_pct = 23; end
            endcase
            sent = 0;
            while (sent < 15)
            begin
                int n;
                n = pick_len();
                if ($urandom_range(9) == 0)
                    send_word(1'b1, 8'($urandom_range(255)));
                else
                    send_message(n, $urandom_range(9) == 0 ? 1 : 2);
                sent += n + 1;
                if ($urandom_range(7) == 0)
                    drain();
            end
            drain();
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        drain();
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("sha256_stream_hasher_core test passed");
        else
            $display("sha256_stream_hasher_core test failed");
        $finish;
    end

endmodule

### files.f
rtl/sha_pkg.sv
rtl/sha_in_if.sv
rtl/sha_out_if.sv
rtl/sha_engine.sv
rtl/sha256_stream_hasher_core.sv
test/sha256_stream_hasher_core_checker.sv
test/sha256_stream_hasher_core_tb.sv
